[rtl/core/thc_pkg.sv]
// ----------------------------------------------------------------------------
// Tilt-compensated heading package
// Shared widths, fixed-point constants, arctangent table and the data that
// travels between the CORDIC and divider cells.
// ----------------------------------------------------------------------------
package thc_pkg;

   // Angle format and number of CORDIC iterations.
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int CORDIC_STEPS    = 16;

   // Port field widths.
   localparam int MAG_W  = 16;
   localparam int TILT_W = 17;
   localparam int HEAD_W = 17;

   // Negated tilt, then the angle after reduction into one half turn.
   localparam int ANG_W = TILT_W + 1;
   localparam int RED_W = (ANGLE_FRAC_BITS + 11 > ANG_W) ? ANGLE_FRAC_BITS + 11 : ANG_W + 1;

   // Datapath widths.
   localparam int Z_W    = 64;                  // angle in 1e-16 degree
   localparam int PP_W   = RED_W + 32;          // angle times one part of the unit
   localparam int SPLIT  = 24;                  // split point of the unit constant
   localparam int TRIG_W = 32;                  // Q30 cosine and sine
   localparam int PROD_W = MAG_W + TRIG_W;      // field times Q30
   localparam int TERM_W = TRIG_W + 1;          // product after the first shift
   localparam int QP_W   = TERM_W + TRIG_W;     // triple product
   localparam int XH_W   = PROD_W + 1;          // horizontal field components
   localparam int V_W    = XH_W + 3;            // vectoring datapath
   localparam int QUO_W  = ANGLE_FRAC_BITS + 10;  // rounded angle magnitude
   localparam int SQ_W   = QUO_W + 2;           // signed heading before clamp
   localparam int STG_W  = $clog2((QUO_W > 24) ? QUO_W : 24);

   // Fixed-point constants.
   localparam logic signed [Z_W-1:0] ANG_ONE_DEG = 64'sd10000000000000000;
   localparam logic signed [Z_W-1:0] ANG_UNIT    = ANG_ONE_DEG >>> ANGLE_FRAC_BITS;
   localparam logic signed [31:0] UNIT_HI = 32'(ANG_UNIT >>> SPLIT);
   localparam logic signed [31:0] UNIT_LO = 32'(ANG_UNIT & ((64'sd1 <<< SPLIT) - 64'sd1));
   localparam logic signed [Z_W-1:0] HALF_TURN_Z = 64'sd180 * ANG_ONE_DEG;
   localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 32'sd652032874;

   // Division by the angle unit, which is 2^(16-ANGLE_FRAC_BITS) times 5^16.
   // The quotient is estimated from numerator bits 30 to 61 by a
   // reciprocal multiplication and is then at most one too small.
   localparam int                RCP_PRE    = 30;
   localparam int                RCP_SH     = 54 - ANGLE_FRAC_BITS;
   localparam int                DIV_PRE_SH = 16 - ANGLE_FRAC_BITS;
   localparam logic [31:0]       RCP_MUL    = 32'd1934281311;      // floor(2^68 / 5^16)
   localparam logic [Z_W-1:0]    DIV_ODD    = 64'd152587890625;    // 5^16

   localparam logic signed [RED_W-1:0] FULL_TURN    = RED_W'(360 * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [RED_W-1:0] HALF_TURN    = RED_W'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [RED_W-1:0] QUARTER_TURN = RED_W'(90 * (2 ** ANGLE_FRAC_BITS));

   localparam logic signed [SQ_W-1:0] HEAD_HALF = SQ_W'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [SQ_W-1:0] HEAD_TOP  = SQ_W'(360 * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [SQ_W-1:0] HEAD_MAX  = SQ_W'((2 ** HEAD_W) - 1);

   // Magnetometer sample carried along the pipeline.
   typedef struct packed {
      logic signed [MAG_W-1:0] mx;
      logic signed [MAG_W-1:0] my;
      logic signed [MAG_W-1:0] mz;
   } mag_type;

   // Reduced tilt angle and the flag that negates its cosine and sine.
   typedef struct packed {
      logic                    neg;
      logic signed [RED_W-1:0] ang;
   } red_type;

   // Rotation cell data.
   typedef struct packed {
      logic                     vld;
      logic                     neg;
      logic signed [TRIG_W-1:0] x;
      logic signed [TRIG_W-1:0] y;
      logic signed [Z_W-1:0]    z;
   } rot_type;

   // Vectoring cell data.
   typedef struct packed {
      logic                  vld;
      logic                  hold;
      logic signed [V_W-1:0] x;
      logic signed [V_W-1:0] y;
      logic signed [Z_W-1:0] z;
   } vec_type;

   // Divider data: sign, numerator or remainder, and quotient.
   typedef struct packed {
      logic             vld;
      logic             neg;
      logic [Z_W-1:0]   num;
      logic [QUO_W-1:0] quo;
   } div_type;

   // atan(2^-i) in units of 1e-16 degree.
   function automatic logic signed [Z_W-1:0] atan_val(input logic [STG_W-1:0] i);
      logic signed [Z_W-1:0] v;
      case (i)
         0:  v = 64'sd450000000000000000;
         1:  v = 64'sd265650511770779893;
         2:  v = 64'sd140362434679264774;
         3:  v = 64'sd71250163489017975;
         4:  v = 64'sd35763343749973511;
         5:  v = 64'sd17899106082460693;
         6:  v = 64'sd8951737102110744;
         7:  v = 64'sd4476141708605531;
         8:  v = 64'sd2238105003685381;
         9:  v = 64'sd1119056770662069;
         10: v = 64'sd559528918938037;
         11: v = 64'sd279764526170037;
         12: v = 64'sd139882271422650;
         13: v = 64'sd69941136753529;
         14: v = 64'sd34970568507040;
         15: v = 64'sd17485284269805;
         16: v = 64'sd8742642136938;
         17: v = 64'sd4371321068723;
         18: v = 64'sd2185660534393;
         19: v = 64'sd1092830267201;
         20: v = 64'sd546415133601;
         21: v = 64'sd273207566800;
         22: v = 64'sd136603783400;
         23: v = 64'sd68301891700;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/thc_rot_cell.sv]
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One registered micro-rotation that drives the residual angle toward zero.
// ----------------------------------------------------------------------------
module thc_rot_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [thc_pkg::STG_W-1:0] stage,
   input  thc_pkg::rot_type          cell_in,
   output thc_pkg::rot_type          cell_out
);
   import thc_pkg::*;

   rot_type step_ff;
   rot_type step_in;
   logic signed [TRIG_W-1:0] xs;
   logic signed [TRIG_W-1:0] ys;

   // Rotate toward the remaining angle.
   always_comb begin
      xs = $signed(cell_in.x) >>> stage;
      ys = $signed(cell_in.y) >>> stage;
      step_in = cell_in;
      if ($signed(cell_in.z) >= 0) begin
         step_in.x = cell_in.x - ys;
         step_in.y = cell_in.y + xs;
         step_in.z = cell_in.z - atan_val(stage);
      end else begin
         step_in.x = cell_in.x + ys;
         step_in.y = cell_in.y - xs;
         step_in.z = cell_in.z + atan_val(stage);
      end
   end

   // Stage register; reset clears the valid flag only.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.vld <= 1'b0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

[rtl/core/thc_vec_cell.sv]
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One registered micro-rotation that drives the vector onto the X axis and
// accumulates the angle turned.
// ----------------------------------------------------------------------------
module thc_vec_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [thc_pkg::STG_W-1:0] stage,
   input  thc_pkg::vec_type          cell_in,
   output thc_pkg::vec_type          cell_out
);
   import thc_pkg::*;

   vec_type step_ff;
   vec_type step_in;
   logic signed [V_W-1:0] xs;
   logic signed [V_W-1:0] ys;

   // Rotate toward the X axis; a zero vector keeps its angle at zero.
   always_comb begin
      xs = $signed(cell_in.x) >>> stage;
      ys = $signed(cell_in.y) >>> stage;
      step_in = cell_in;
      if ($signed(cell_in.y) < 0) begin
         step_in.x = cell_in.x - ys;
         step_in.y = cell_in.y + xs;
         if (!cell_in.hold) begin
            step_in.z = cell_in.z - atan_val(stage);
         end
      end else begin
         step_in.x = cell_in.x + ys;
         step_in.y = cell_in.y - xs;
         if (!cell_in.hold) begin
            step_in.z = cell_in.z + atan_val(stage);
         end
      end
   end

   // Stage register; reset clears the valid flag only.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.vld <= 1'b0;
      end else begin
         step_ff <= step_in;
      end
   end

   assign cell_out = step_ff;

endmodule

[rtl/core/thc_div_cell.sv]
// ----------------------------------------------------------------------------
// Divider cell
// Division by the angle unit in three registered steps: a reciprocal
// estimate, the back-multiplication and a one-step correction.
// ----------------------------------------------------------------------------
module thc_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  thc_pkg::div_type cell_in,
   output thc_pkg::div_type cell_out
);
   import thc_pkg::*;

   // Step 1: numerator over the power of two and the reciprocal product.
   logic             e_vld_ff, e_vld_in;
   logic             e_neg_ff, e_neg_in;
   logic [Z_W-1:0]   e_num_ff, e_num_in;
   logic [Z_W-1:0]   e_prd_ff, e_prd_in;
   logic [31:0]      e_hi;

   // Step 2: estimated quotient and its product with the odd divisor.
   logic             m_vld_ff, m_vld_in;
   logic             m_neg_ff, m_neg_in;
   logic [Z_W-1:0]   m_num_ff, m_num_in;
   logic [QUO_W-1:0] m_quo_ff, m_quo_in;
   logic [Z_W-1:0]   m_back_ff, m_back_in;

   // Step 3: corrected quotient.
   div_type          step_ff;
   div_type          step_in;
   logic [Z_W-1:0]   rem;

   // The estimate is never too large and at most one too small.
   always_comb begin
      e_hi      = cell_in.num[RCP_PRE +: 32];
      e_vld_in  = cell_in.vld;
      e_neg_in  = cell_in.neg;
      e_num_in  = cell_in.num >> DIV_PRE_SH;
      e_prd_in  = Z_W'(e_hi) * Z_W'(RCP_MUL);

      m_vld_in  = e_vld_ff;
      m_neg_in  = e_neg_ff;
      m_num_in  = e_num_ff;
      m_quo_in  = QUO_W'(e_prd_ff >> RCP_SH);
      m_back_in = Z_W'(m_quo_in) * DIV_ODD;

      rem          = m_num_ff - m_back_ff;
      step_in.vld  = m_vld_ff;
      step_in.neg  = m_neg_ff;
      step_in.num  = rem;
      step_in.quo  = (rem >= DIV_ODD) ? m_quo_ff + QUO_W'(1) : m_quo_ff;
   end

   // Valid flags; reset clears them only.
   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff    <= 1'b0;
         m_vld_ff    <= 1'b0;
         step_ff.vld <= 1'b0;
      end else begin
         e_vld_ff    <= e_vld_in;
         m_vld_ff    <= m_vld_in;
         step_ff     <= step_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      e_neg_ff  <= e_neg_in;
      e_num_ff  <= e_num_in;
      e_prd_ff  <= e_prd_in;
      m_neg_ff  <= m_neg_in;
      m_num_ff  <= m_num_in;
      m_quo_ff  <= m_quo_in;
      m_back_ff <= m_back_in;
   end

   assign cell_out = step_ff;

endmodule

[rtl/core/tilt_compensated_heading.sv]
// ----------------------------------------------------------------------------
// Tilt-compensated compass heading
// Fully pipelined: tilt reduction, two rotation CORDIC chains, projection
// onto the horizontal plane, a vectoring CORDIC chain and a rounding divider.
// ----------------------------------------------------------------------------
// The block takes a new request in every clock cycle and busy is always low.
// Each request gives exactly one heading, strobed by rsp_valid for one cycle,
// once it has passed stages 0 to 3, the rotation CORDIC cells, stages 4 to
// 8, the vectoring CORDIC cells, stage 9, the three divider steps and the
// result register. The receiver cannot stall the pipeline, so it must
// take every strobed result.
module tilt_compensated_heading (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [thc_pkg::MAG_W-1:0]  req_mag_x,
   input  logic signed [thc_pkg::MAG_W-1:0]  req_mag_y,
   input  logic signed [thc_pkg::MAG_W-1:0]  req_mag_z,
   input  logic signed [thc_pkg::TILT_W-1:0] req_tilt_x,
   input  logic signed [thc_pkg::TILT_W-1:0] req_tilt_y,
   output logic                              rsp_valid,
   output logic [thc_pkg::HEAD_W-1:0]        rsp_heading
);
   import thc_pkg::*;

   // Reduce an angle into [-90, 90] degrees, noting a folded half turn.
   function automatic red_type reduce_angle(input logic signed [RED_W-1:0] a);
      red_type                 r;
      logic signed [RED_W-1:0] m;
      m = a;
      if (a >= HALF_TURN) begin
         m = a - FULL_TURN;
      end else if (a < -HALF_TURN) begin
         m = a + FULL_TURN;
      end
      r.neg = 1'b0;
      if (m > QUARTER_TURN) begin
         m = m - HALF_TURN;
         r.neg = 1'b1;
      end else if (m < -QUARTER_TURN) begin
         m = m + HALF_TURN;
         r.neg = 1'b1;
      end
      r.ang = m;
      return r;
   endfunction

   // Stage 0: request register with negated tilts.
   logic                    s0_vld_ff, s0_vld_in;
   mag_type                 s0_mag_ff, s0_mag_in;
   logic signed [RED_W-1:0] s0_nx_ff, s0_nx_in;
   logic signed [RED_W-1:0] s0_ny_ff, s0_ny_in;

   // Stage 1: reduced angles.
   logic    s1_vld_ff, s1_vld_in;
   mag_type s1_mag_ff, s1_mag_in;
   red_type s1_rx_ff, s1_rx_in;
   red_type s1_ry_ff, s1_ry_in;

   // Stage 2: partial products of angle times unit.
   logic                   s2_vld_ff, s2_vld_in;
   mag_type                s2_mag_ff, s2_mag_in;
   logic                   s2_negx_ff, s2_negx_in;
   logic                   s2_negy_ff, s2_negy_in;
   logic signed [PP_W-1:0] s2_hx_ff, s2_hx_in;
   logic signed [PP_W-1:0] s2_lx_ff, s2_lx_in;
   logic signed [PP_W-1:0] s2_hy_ff, s2_hy_in;
   logic signed [PP_W-1:0] s2_ly_ff, s2_ly_in;

   // Stage 3: angles in 1e-16 degree.
   logic                  s3_vld_ff, s3_vld_in;
   mag_type               s3_mag_ff, s3_mag_in;
   logic                  s3_negx_ff, s3_negx_in;
   logic                  s3_negy_ff, s3_negy_in;
   logic signed [Z_W-1:0] s3_zx_ff, s3_zx_in;
   logic signed [Z_W-1:0] s3_zy_ff, s3_zy_in;

   // Sample delay alongside the rotation chains.
   mag_type mag_dly_ff [CORDIC_STEPS];

   rot_type rx_chain [CORDIC_STEPS+1];
   rot_type ry_chain [CORDIC_STEPS+1];

   // Stage 4: cosine and sine with the folded half turn applied.
   logic                     s4_vld_ff, s4_vld_in;
   mag_type                  s4_mag_ff, s4_mag_in;
   logic signed [TRIG_W-1:0] s4_cx_ff, s4_cx_in;
   logic signed [TRIG_W-1:0] s4_sx_ff, s4_sx_in;
   logic signed [TRIG_W-1:0] s4_cy_ff, s4_cy_in;
   logic signed [TRIG_W-1:0] s4_sy_ff, s4_sy_in;

   // Stage 5: field times trig products.
   logic                     s5_vld_ff, s5_vld_in;
   logic signed [TRIG_W-1:0] s5_sx_ff, s5_sx_in;
   logic signed [PROD_W-1:0] s5_p1_ff, s5_p1_in;
   logic signed [PROD_W-1:0] s5_p2_ff, s5_p2_in;
   logic signed [PROD_W-1:0] s5_p3_ff, s5_p3_in;
   logic signed [PROD_W-1:0] s5_p4_ff, s5_p4_in;
   logic signed [PROD_W-1:0] s5_p5_ff, s5_p5_in;

   // Stage 6: triple products and the Y component.
   logic                     s6_vld_ff, s6_vld_in;
   logic signed [PROD_W-1:0] s6_p1_ff, s6_p1_in;
   logic signed [QP_W-1:0]   s6_q2_ff, s6_q2_in;
   logic signed [QP_W-1:0]   s6_q3_ff, s6_q3_in;
   logic signed [XH_W-1:0]   s6_yh_ff, s6_yh_in;
   logic signed [TERM_W-1:0] t2, t3;

   // Stage 7: horizontal components.
   logic                   s7_vld_ff, s7_vld_in;
   logic signed [XH_W-1:0] s7_xh_ff, s7_xh_in;
   logic signed [XH_W-1:0] s7_yh_ff, s7_yh_in;

   // Stage 8: vectoring start.
   vec_type s8_ff, s8_in;
   vec_type vx_chain [CORDIC_STEPS+1];

   // Stage 9: magnitude plus half a unit, ready for the divider.
   div_type               s9_ff, s9_in;
   logic signed [Z_W-1:0] zmag;
   div_type               dv_out;

   // Result register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [HEAD_W-1:0]      rsp_heading_ff, rsp_heading_in;
   logic signed [SQ_W-1:0] hsum;

   // The pipeline never stalls.
   assign busy = 1'b0;

   // Stage 0 next values.
   always_comb begin
      s0_vld_in = start & ~busy;
      s0_mag_in.mx = req_mag_x;
      s0_mag_in.my = req_mag_y;
      s0_mag_in.mz = req_mag_z;
      s0_nx_in = -RED_W'(req_tilt_x);
      s0_ny_in = -RED_W'(req_tilt_y);
   end

   // Stages 1 to 3: reduce the angles and scale them to 1e-16 degree.
   always_comb begin
      s1_vld_in  = s0_vld_ff;
      s1_mag_in  = s0_mag_ff;
      s1_rx_in   = reduce_angle(s0_nx_ff);
      s1_ry_in   = reduce_angle(s0_ny_ff);
      s2_vld_in  = s1_vld_ff;
      s2_mag_in  = s1_mag_ff;
      s2_negx_in = s1_rx_ff.neg;
      s2_negy_in = s1_ry_ff.neg;
      s2_hx_in   = s1_rx_ff.ang * UNIT_HI;
      s2_lx_in   = s1_rx_ff.ang * UNIT_LO;
      s2_hy_in   = s1_ry_ff.ang * UNIT_HI;
      s2_ly_in   = s1_ry_ff.ang * UNIT_LO;
      s3_vld_in  = s2_vld_ff;
      s3_mag_in  = s2_mag_ff;
      s3_negx_in = s2_negx_ff;
      s3_negy_in = s2_negy_ff;
      s3_zx_in   = (Z_W'(s2_hx_ff) <<< SPLIT) + Z_W'(s2_lx_ff);
      s3_zy_in   = (Z_W'(s2_hy_ff) <<< SPLIT) + Z_W'(s2_ly_ff);
   end

   // Heads of the two rotation chains.
   always_comb begin
      rx_chain[0].vld = s3_vld_ff;
      rx_chain[0].neg = s3_negx_ff;
      rx_chain[0].x   = INV_GAIN_Q30;
      rx_chain[0].y   = '0;
      rx_chain[0].z   = s3_zx_ff;
      ry_chain[0].vld = s3_vld_ff;
      ry_chain[0].neg = s3_negy_ff;
      ry_chain[0].x   = INV_GAIN_Q30;
      ry_chain[0].y   = '0;
      ry_chain[0].z   = s3_zy_ff;
   end

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
      thc_rot_cell u_rot_x (
         .clock    (clock),
         .reset    (reset),
         .stage    (STG_W'(k)),
         .cell_in  (rx_chain[k]),
         .cell_out (rx_chain[k+1])
      );
      thc_rot_cell u_rot_y (
         .clock    (clock),
         .reset    (reset),
         .stage    (STG_W'(k)),
         .cell_in  (ry_chain[k]),
         .cell_out (ry_chain[k+1])
      );
   end

   // Stages 4 to 7: trig sign, products and the horizontal projection.
   always_comb begin
      s4_vld_in = rx_chain[CORDIC_STEPS].vld & ry_chain[CORDIC_STEPS].vld;
      s4_mag_in = mag_dly_ff[CORDIC_STEPS-1];
      s4_cx_in  = rx_chain[CORDIC_STEPS].neg ? -rx_chain[CORDIC_STEPS].x
                                             : rx_chain[CORDIC_STEPS].x;
      s4_sx_in  = rx_chain[CORDIC_STEPS].neg ? -rx_chain[CORDIC_STEPS].y
                                             : rx_chain[CORDIC_STEPS].y;
      s4_cy_in  = ry_chain[CORDIC_STEPS].neg ? -ry_chain[CORDIC_STEPS].x
                                             : ry_chain[CORDIC_STEPS].x;
      s4_sy_in  = ry_chain[CORDIC_STEPS].neg ? -ry_chain[CORDIC_STEPS].y
                                             : ry_chain[CORDIC_STEPS].y;

      s5_vld_in = s4_vld_ff;
      s5_sx_in  = s4_sx_ff;
      s5_p1_in  = s4_mag_ff.mx * s4_cx_ff;
      s5_p2_in  = s4_mag_ff.my * s4_sy_ff;
      s5_p3_in  = s4_mag_ff.mz * s4_cy_ff;
      s5_p4_in  = s4_mag_ff.my * s4_cy_ff;
      s5_p5_in  = s4_mag_ff.mz * s4_sy_ff;

      t2 = TERM_W'(s5_p2_ff >>> 14);
      t3 = TERM_W'(s5_p3_ff >>> 14);
      s6_vld_in = s5_vld_ff;
      s6_p1_in  = s5_p1_ff;
      s6_q2_in  = t2 * s5_sx_ff;
      s6_q3_in  = t3 * s5_sx_ff;
      s6_yh_in  = XH_W'(s5_p4_ff) + XH_W'(s5_p5_ff);

      s7_vld_in = s6_vld_ff;
      s7_xh_in  = XH_W'(s6_p1_ff) + XH_W'(s6_q2_ff >>> 16) - XH_W'(s6_q3_ff >>> 16);
      s7_yh_in  = s6_yh_ff;
   end

   // Stage 8: a vector with negative X is turned by a half turn first.
   always_comb begin
      s8_in.vld  = s7_vld_ff;
      s8_in.hold = (s7_xh_ff == '0) && (s7_yh_ff == '0);
      s8_in.x    = V_W'(s7_xh_ff);
      s8_in.y    = V_W'(s7_yh_ff);
      s8_in.z    = '0;
      if (s7_xh_ff < 0) begin
         s8_in.x = -V_W'(s7_xh_ff);
         s8_in.y = -V_W'(s7_yh_ff);
         s8_in.z = (s7_yh_ff >= 0) ? HALF_TURN_Z : -HALF_TURN_Z;
      end
   end

   assign vx_chain[0] = s8_ff;

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
      thc_vec_cell u_vec (
         .clock    (clock),
         .reset    (reset),
         .stage    (STG_W'(k)),
         .cell_in  (vx_chain[k]),
         .cell_out (vx_chain[k+1])
      );
   end

   // Stage 9: round half away from zero by dividing the magnitude.
   always_comb begin
      zmag = vx_chain[CORDIC_STEPS].z[Z_W-1] ? -vx_chain[CORDIC_STEPS].z
                                             : vx_chain[CORDIC_STEPS].z;
      s9_in.vld = vx_chain[CORDIC_STEPS].vld;
      s9_in.neg = vx_chain[CORDIC_STEPS].z[Z_W-1];
      s9_in.num = unsigned'(zmag) + unsigned'(ANG_UNIT >>> 1);
      s9_in.quo = '0;
   end

   thc_div_cell u_div (
      .clock    (clock),
      .reset    (reset),
      .cell_in  (s9_ff),
      .cell_out (dv_out)
   );

   // Result: add the half turn and clamp to the output range.
   always_comb begin
      hsum = dv_out.neg ? -SQ_W'(dv_out.quo) : SQ_W'(dv_out.quo);
      hsum = hsum + HEAD_HALF;
      if (hsum < 0) begin
         hsum = '0;
      end
      if (hsum > HEAD_TOP) begin
         hsum = HEAD_TOP;
      end
      if (hsum > HEAD_MAX) begin
         hsum = HEAD_MAX;
      end
      rsp_valid_in   = dv_out.vld;
      rsp_heading_in = hsum[HEAD_W-1:0];
   end

   // Valid flags of the pipeline stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         s4_vld_ff    <= 1'b0;
         s5_vld_ff    <= 1'b0;
         s6_vld_ff    <= 1'b0;
         s7_vld_ff    <= 1'b0;
         s8_ff.vld    <= 1'b0;
         s9_ff.vld    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s0_vld_ff    <= s0_vld_in;
         s1_vld_ff    <= s1_vld_in;
         s2_vld_ff    <= s2_vld_in;
         s3_vld_ff    <= s3_vld_in;
         s4_vld_ff    <= s4_vld_in;
         s5_vld_ff    <= s5_vld_in;
         s6_vld_ff    <= s6_vld_in;
         s7_vld_ff    <= s7_vld_in;
         s8_ff        <= s8_in;
         s9_ff        <= s9_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      s0_mag_ff  <= s0_mag_in;
      s0_nx_ff   <= s0_nx_in;
      s0_ny_ff   <= s0_ny_in;
      s1_mag_ff  <= s1_mag_in;
      s1_rx_ff   <= s1_rx_in;
      s1_ry_ff   <= s1_ry_in;
      s2_mag_ff  <= s2_mag_in;
      s2_negx_ff <= s2_negx_in;
      s2_negy_ff <= s2_negy_in;
      s2_hx_ff   <= s2_hx_in;
      s2_lx_ff   <= s2_lx_in;
      s2_hy_ff   <= s2_hy_in;
      s2_ly_ff   <= s2_ly_in;
      s3_mag_ff  <= s3_mag_in;
      s3_negx_ff <= s3_negx_in;
      s3_negy_ff <= s3_negy_in;
      s3_zx_ff   <= s3_zx_in;
      s3_zy_ff   <= s3_zy_in;
      mag_dly_ff[0] <= s3_mag_ff;
      for (int k = 1; k < CORDIC_STEPS; k++) begin
         mag_dly_ff[k] <= mag_dly_ff[k-1];
      end
      s4_mag_ff  <= s4_mag_in;
      s4_cx_ff   <= s4_cx_in;
      s4_sx_ff   <= s4_sx_in;
      s4_cy_ff   <= s4_cy_in;
      s4_sy_ff   <= s4_sy_in;
      s5_sx_ff   <= s5_sx_in;
      s5_p1_ff   <= s5_p1_in;
      s5_p2_ff   <= s5_p2_in;
      s5_p3_ff   <= s5_p3_in;
      s5_p4_ff   <= s5_p4_in;
      s5_p5_ff   <= s5_p5_in;
      s6_p1_ff   <= s6_p1_in;
      s6_q2_ff   <= s6_q2_in;
      s6_q3_ff   <= s6_q3_in;
      s6_yh_ff   <= s6_yh_in;
      s7_xh_ff   <= s7_xh_in;
      s7_yh_ff   <= s7_yh_in;
      rsp_heading_ff <= rsp_heading_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_heading = rsp_heading_ff;

endmodule

[verif/tb_tilt_compensated_heading.sv]
// ----------------------------------------------------------------------------
// Tilt-compensated heading testbench
// Drives magnetometer and tilt requests with random gaps, predicts each
// heading with an independent CORDIC model and checks every strobed result.
// ----------------------------------------------------------------------------
module tb_tilt_compensated_heading;
   import thc_pkg::*;

   localparam longint ONE_DEG  = 64'sd10000000000000000;
   localparam longint INV_GAIN = 64'sd652032874;
   localparam int     N_ITEMS  = 1300;

   // Arctangent of 2^-i in units of 1e-16 degree.
   localparam longint ATAN_DEG [0:23] = '{
      64'sd450000000000000000, 64'sd265650511770779893, 64'sd140362434679264774,
      64'sd71250163489017975, 64'sd35763343749973511, 64'sd17899106082460693,
      64'sd8951737102110744, 64'sd4476141708605531, 64'sd2238105003685381,
      64'sd1119056770662069, 64'sd559528918938037, 64'sd279764526170037,
      64'sd139882271422650, 64'sd69941136753529, 64'sd34970568507040,
      64'sd17485284269805, 64'sd8742642136938, 64'sd4371321068723,
      64'sd2185660534393, 64'sd1092830267201, 64'sd546415133601,
      64'sd273207566800, 64'sd136603783400, 64'sd68301891700};

   typedef struct {
      logic signed [MAG_W-1:0]  mx;
      logic signed [MAG_W-1:0]  my;
      logic signed [MAG_W-1:0]  mz;
      logic signed [TILT_W-1:0] tx;
      logic signed [TILT_W-1:0] ty;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [MAG_W-1:0]  req_mag_x = '0;
   logic signed [MAG_W-1:0]  req_mag_y = '0;
   logic signed [MAG_W-1:0]  req_mag_z = '0;
   logic signed [TILT_W-1:0] req_tilt_x = '0;
   logic signed [TILT_W-1:0] req_tilt_y = '0;
   logic rsp_valid;
   logic [HEAD_W-1:0] rsp_heading;

   sample_type pending_samples[$];
   logic [HEAD_W-1:0] expected_headings[$];
   logic   took = 1'b0;
   int     gap_left = 0;
   int     mismatches = 0;
   bit     failed = 1'b0;

   tilt_compensated_heading u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mag_x(req_mag_x), .req_mag_y(req_mag_y), .req_mag_z(req_mag_z),
      .req_tilt_x(req_tilt_x), .req_tilt_y(req_tilt_y),
      .rsp_valid(rsp_valid), .rsp_heading(rsp_heading));

   initial begin
      forever #6 clock = ~clock;
   end

   // Cosine and sine in Q30 of an angle in input units, by rotation CORDIC.
   function automatic void rotate_angle(input longint a, output longint c,
                                        output longint s);
      longint full, half, quarter, unit, m, x, y, z, t;
      bit     flip;
      full    = 360 <<< ANGLE_FRAC_BITS;
      half    = 180 <<< ANGLE_FRAC_BITS;
      quarter = 90 <<< ANGLE_FRAC_BITS;
      unit    = ONE_DEG >>> ANGLE_FRAC_BITS;
      m = ((a % full) + full) % full;
      flip = 1'b0;
      if (m >= half) m -= full;
      if (m > quarter) begin
         m -= half;
         flip = 1'b1;
      end else if (m < -quarter) begin
         m += half;
         flip = 1'b1;
      end
      x = INV_GAIN;
      y = 0;
      z = m * unit;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= ATAN_DEG[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += ATAN_DEG[i];
         end
         x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Heading of one sample in 1/2^ANGLE_FRAC_BITS degree.
   function automatic logic [HEAD_W-1:0] compass_heading(sample_type smp);
      longint cx, sx, cy, sy, xh, yh, x, y, z, t, q, h, unit;
      unit = ONE_DEG >>> ANGLE_FRAC_BITS;
      rotate_angle(-longint'(smp.tx), cx, sx);
      rotate_angle(-longint'(smp.ty), cy, sy);
      xh = longint'(smp.mx) * cx
         + ((((longint'(smp.my) * sy) >>> 14) * sx) >>> 16)
         - ((((longint'(smp.mz) * cy) >>> 14) * sx) >>> 16);
      yh = longint'(smp.my) * cy + longint'(smp.mz) * sy;
      // Vectoring CORDIC; a vector in the left half plane is turned first.
      z = 0;
      if (xh != 0 || yh != 0) begin
         x = xh;
         y = yh;
         if (x < 0) begin
            z = (y >= 0) ? 180 * ONE_DEG : -180 * ONE_DEG;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y < 0) begin
               t = x - (y >>> i);
               y = y + (x >>> i);
               z -= ATAN_DEG[i];
            end else begin
               t = x + (y >>> i);
               y = y - (x >>> i);
               z += ATAN_DEG[i];
            end
            x = t;
         end
      end
      // Round half away from zero, offset by a half turn and clamp.
      if (z >= 0) q = (z + unit / 2) / unit;
      else q = -((-z + unit / 2) / unit);
      h = q + (180 <<< ANGLE_FRAC_BITS);
      if (h < 0) h = 0;
      if (h > (360 <<< ANGLE_FRAC_BITS)) h = 360 <<< ANGLE_FRAC_BITS;
      if (h > (2 ** HEAD_W) - 1) h = (2 ** HEAD_W) - 1;
      return HEAD_W'(h);
   endfunction

   // Driver: presents the next request at the falling edge after a random gap.
   always @(negedge clock) begin
      sample_type smp;
      logic       nxt_start;
      int         r;
      nxt_start = start;
      if (!reset && (!start || took)) begin
         nxt_start = 1'b0;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_samples.size() > 0) begin
            smp = pending_samples.pop_front();
            nxt_start = 1'b1;
            req_mag_x  <= smp.mx;
            req_mag_y  <= smp.my;
            req_mag_z  <= smp.mz;
            req_tilt_x <= smp.tx;
            req_tilt_y <= smp.ty;
            r = $urandom_range(0, 99);
            if (r < 65) gap_left <= 0;
            else if (r < 93) gap_left <= $urandom_range(1, 3);
            else gap_left <= $urandom_range(10, 40);
         end
      end
      start <= nxt_start;
   end

   // Monitor: records accepted requests and checks strobed headings.
   always @(posedge clock) begin
      sample_type smp;
      logic [HEAD_W-1:0] want;
      took <= start && !busy && !reset;
      if (!reset && start && !busy) begin
         smp.mx = req_mag_x;
         smp.my = req_mag_y;
         smp.mz = req_mag_z;
         smp.tx = req_tilt_x;
         smp.ty = req_tilt_y;
         expected_headings.push_back(compass_heading(smp));
      end
      if (!reset && rsp_valid) begin
         if (expected_headings.size() == 0) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10) $display("Unexpected heading %0d", rsp_heading);
         end else begin
            want = expected_headings.pop_front();
            if (rsp_heading !== want) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= 10)
                  $display("Heading mismatch: expected %0d, got %0d", want, rsp_heading);
            end
         end
      end
   end

   function automatic sample_type make_sample(int mx, int my, int mz, int tx, int ty);
      sample_type smp;
      smp.mx = MAG_W'(mx);
      smp.my = MAG_W'(my);
      smp.mz = MAG_W'(mz);
      smp.tx = TILT_W'(tx);
      smp.ty = TILT_W'(ty);
      return smp;
   endfunction

   // Stimulus and end of run.
   initial begin
      sample_type smp;
      // Directed requests: extremes, zero field, left half plane, folded tilts.
      pending_samples.push_back(make_sample(0, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(-1000, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(1000, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(0, 1000, 0, 0, 0));
      pending_samples.push_back(make_sample(0, -1000, 0, 0, 0));
      pending_samples.push_back(make_sample(32767, 32767, 32767, 46080, 46080));
      pending_samples.push_back(make_sample(-32768, -32768, -32768, -46080, -46080));
      pending_samples.push_back(make_sample(-32768, 32767, -32768, 46080, -46080));
      pending_samples.push_back(make_sample(500, 300, -200, 23040, -23040));
      pending_samples.push_back(make_sample(500, 300, -200, 23041, -23041));
      pending_samples.push_back(make_sample(-500, 300, 200, 30000, -40000));
      pending_samples.push_back(make_sample(-32768, -1, 0, 0, 0));
      pending_samples.push_back(make_sample(-32768, 1, 0, 0, 0));
      pending_samples.push_back(make_sample(0, 0, 32767, 23040, 0));
      pending_samples.push_back(make_sample(0, 0, -32768, 0, 23040));
      pending_samples.push_back(make_sample(1, 0, 0, 0, 0));
      pending_samples.push_back(make_sample(12000, -8000, 30000, 5120, -7680));
      pending_samples.push_back(make_sample(-20000, 15000, -25000, -11520, 34560));
      // Random requests: full-range field, mostly realistic tilt, some over the full tilt range.
      for (int n = 0; n < N_ITEMS; n++) begin
         smp.mx = MAG_W'($urandom);
         smp.my = MAG_W'($urandom);
         smp.mz = MAG_W'($urandom);
         if ($urandom_range(0, 3) == 0) begin
            smp.tx = TILT_W'($urandom);
            smp.ty = TILT_W'($urandom);
         end else begin
            smp.tx = TILT_W'($urandom_range(0, 46080) - 23040);
            smp.ty = TILT_W'($urandom_range(0, 46080) - 23040);
         end
         if ($urandom_range(0, 9) == 0) begin
            smp.my = '0;
            smp.mz = '0;
            smp.tx = '0;
         end
         pending_samples.push_back(smp);
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait (pending_samples.size() == 0 && !start);
      wait (expected_headings.size() == 0);
      repeat (100) @(posedge clock);
      if (!failed && expected_headings.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a hung pipeline.
   initial begin
      #6000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

[tilt_compensated_heading.f]
rtl/core/thc_pkg.sv
rtl/core/thc_rot_cell.sv
rtl/core/thc_vec_cell.sv
rtl/core/thc_div_cell.sv
rtl/core/tilt_compensated_heading.sv
verif/tb_tilt_compensated_heading.sv
